// ===== design/u8s_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 sanitiser.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package u8s_pkg;

  // Depth of the work queue between classifier and byte expander
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // Replacement character U+FFFD in UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Lead bytes with a restricted second-byte range
  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;

  typedef enum logic [4:0] {
    CLS_ASCII = 5'b00001,
    CLS_LEAD2 = 5'b00010,
    CLS_LEAD3 = 5'b00100,
    CLS_LEAD4 = 5'b01000,
    CLS_BAD   = 5'b10000
  } byte_cls_t;

  // One queue entry: a run of replacement triples, then literal bytes
  typedef struct packed {
    logic [2:0]      repl_cnt;  // 0..4 triples
    logic [2:0]      lit_cnt;   // 0..4 literal bytes
    logic [3:0][7:0] lits;
  } run_desc_t;

  function automatic byte_cls_t classify(input logic [7:0] b);
    byte_cls_t c;
    if (b < 8'h80)                      c = CLS_ASCII;
    else if (b >= 8'hC2 && b <= 8'hDF)  c = CLS_LEAD2;
    else if (b >= 8'hE0 && b <= 8'hEF)  c = CLS_LEAD3;
    else if (b >= 8'hF0 && b <= 8'hF4)  c = CLS_LEAD4;
    else                                c = CLS_BAD;
    return c;
  endfunction

  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    ok = 1'b1;
    if (lead == LEAD_E0 && b < 8'hA0) ok = 1'b0;
    if (lead == LEAD_ED && b > 8'h9F) ok = 1'b0;
    if (lead == LEAD_F0 && b < 8'h90) ok = 1'b0;
    if (lead == LEAD_F4 && b > 8'h8F) ok = 1'b0;
    return ok;
  endfunction

endpackage

`default_nettype wire

// ===== design/u8s_front.sv =====
// Classifier: tracks the pending multi-byte sequence and turns each byte
// into a run descriptor for the expander. Depends on u8s_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8s_front import u8s_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc_i,       // input transaction taken this cycle
  input  wire logic [7:0] data_i,
  input  wire logic       eot_i,
  output logic            q_push_o,
  output run_desc_t       q_desc_o
);

  logic [7:0] lead_r,     lead_nxt;
  logic [2:0] need_r,     need_nxt;   // 0 = nothing pending
  logic [1:0] held_cnt_r, held_cnt_nxt;
  // Only two continuation bytes are ever held: a four-byte form completes
  // on its third continuation.
  logic [7:0] held_r [2];

  logic       pending, cont, ok, complete, fresh;
  byte_cls_t  cls;
  logic [2:0] flush_k, bad_k, eot_k, lit_cnt;
  logic       fresh_lead;
  logic [3:0][7:0] lits;

  always_comb begin
    pending    = (need_r != 3'd0);
    cont       = (data_i[7:6] == 2'b10);
    ok         = pending && cont && ((held_cnt_r != 2'd0) || second_ok(lead_r, data_i));
    complete   = ok && (({1'b0, held_cnt_r} + 3'd2) >= need_r);
    fresh      = !ok;
    cls        = classify(data_i);
    fresh_lead = fresh && (cls == CLS_LEAD2 || cls == CLS_LEAD3 || cls == CLS_LEAD4);

    flush_k = (pending && !ok) ? ({1'b0, held_cnt_r} + 3'd1) : 3'd0;
    bad_k   = (fresh && cls == CLS_BAD) ? 3'd1 : 3'd0;
    eot_k   = 3'd0;
    if (eot_i) begin
      if (ok && !complete) eot_k = {1'b0, held_cnt_r} + 3'd2;
      else if (fresh_lead)  eot_k = 3'd1;
    end

    lits    = '0;
    lit_cnt = 3'd0;
    if (complete) begin
      lit_cnt = {1'b0, held_cnt_r} + 3'd2;
      lits[0] = lead_r;
      lits[1] = (held_cnt_r == 2'd0) ? data_i : held_r[0];
      lits[2] = (held_cnt_r == 2'd1) ? data_i : held_r[1];
      lits[3] = data_i;
    end else if (fresh && cls == CLS_ASCII) begin
      lit_cnt = 3'd1;
      lits[0] = data_i;
    end

    q_desc_o.repl_cnt = flush_k + bad_k + eot_k;
    q_desc_o.lit_cnt  = lit_cnt;
    q_desc_o.lits     = lits;
    q_push_o = acc_i && ((q_desc_o.repl_cnt != 3'd0) || (lit_cnt != 3'd0));

    lead_nxt     = lead_r;
    need_nxt     = need_r;
    held_cnt_nxt = held_cnt_r;
    if (ok) begin
      if (complete) begin
        lead_nxt = '0; need_nxt = 3'd0; held_cnt_nxt = 2'd0;
      end else begin
        held_cnt_nxt = held_cnt_r + 2'd1;
      end
    end else begin
      lead_nxt = '0; need_nxt = 3'd0; held_cnt_nxt = 2'd0;
      unique case (cls)
        CLS_LEAD2: begin lead_nxt = data_i; need_nxt = 3'd2; end
        CLS_LEAD3: begin lead_nxt = data_i; need_nxt = 3'd3; end
        CLS_LEAD4: begin lead_nxt = data_i; need_nxt = 3'd4; end
        default: ;
      endcase
    end
    if (eot_i) begin
      lead_nxt = '0; need_nxt = 3'd0; held_cnt_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r     <= '0;
      need_r     <= 3'd0;
      held_cnt_r <= 2'd0;
    end else if (acc_i) begin
      lead_r     <= lead_nxt;
      need_r     <= need_nxt;
      held_cnt_r <= held_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_i && ok && !complete) begin
      held_r[held_cnt_r[0]] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/u8s_fifo.sv =====
// Short queue of run descriptors between classifier and expander.
// Depends on u8s_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8s_fifo import u8s_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_i,
  input  wire run_desc_t desc_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           avail_o,
  output run_desc_t      head_o
);

  run_desc_t        mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   count_r,  count_nxt;

  assign full_o  = (count_r == QCW'(QDEPTH));
  assign avail_o = (count_r != '0);
  assign head_o  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push_i && !pop_i)      count_nxt = count_r + QCW'(1);
    else if (pop_i && !push_i) count_nxt = count_r - QCW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (pop_i)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= desc_i;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> avail_o)
    else $error("queue read while empty");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    QAW'(wr_ptr_r - rd_ptr_r) == count_r[QAW-1:0])
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== design/u8s_back.sv =====
// Expander: walks the head descriptor one byte per cycle into the output
// register while the receiver takes each byte. Depends on u8s_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8s_back import u8s_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       avail_i,
  input  wire run_desc_t  head_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            out_repl_o,
  output logic            out_last_o,
  input  wire logic       out_take_i    // result transaction this cycle
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       repl_r, last_r;
  logic [2:0] tri_r, tri_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [2:0] lit_r, lit_nxt;

  logic       load, in_repl, cur_last;
  logic [7:0] cur_byte;

  always_comb begin
    load    = avail_i && (!valid_r || out_take_i);
    in_repl = (tri_r < head_i.repl_cnt);

    if (in_repl) begin
      case (sub_r)
        2'd0:    cur_byte = REPL_B0;
        2'd1:    cur_byte = REPL_B1;
        default: cur_byte = REPL_B2;
      endcase
      cur_last = (sub_r == 2'd2) && ((tri_r + 3'd1) == head_i.repl_cnt) &&
                 (head_i.lit_cnt == 3'd0);
    end else begin
      cur_byte = head_i.lits[lit_r[1:0]];
      cur_last = ((lit_r + 3'd1) == head_i.lit_cnt);
    end

    tri_nxt = tri_r;
    sub_nxt = sub_r;
    lit_nxt = lit_r;
    if (load) begin
      if (cur_last) begin
        tri_nxt = 3'd0; sub_nxt = 2'd0; lit_nxt = 3'd0;
      end else if (in_repl) begin
        if (sub_r == 2'd2) begin
          sub_nxt = 2'd0;
          tri_nxt = tri_r + 3'd1;
        end else begin
          sub_nxt = sub_r + 2'd1;
        end
      end else begin
        lit_nxt = lit_r + 3'd1;
      end
    end
  end

  assign q_pop_o     = load && cur_last;
  assign out_valid_o = valid_r;
  assign out_byte_o  = byte_r;
  assign out_repl_o  = repl_r;
  assign out_last_o  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tri_r   <= 3'd0;
      sub_r   <= 2'd0;
      lit_r   <= 3'd0;
    end else begin
      if (load)            valid_r <= 1'b1;
      else if (out_take_i) valid_r <= 1'b0;
      tri_r <= tri_nxt;
      sub_r <= sub_nxt;
      lit_r <= lit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      repl_r <= in_repl;
      last_r <= cur_last;
    end
  end

  a_desc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    avail_i |-> ((head_i.repl_cnt != 3'd0) || (head_i.lit_cnt != 3'd0)))
    else $error("empty run descriptor at queue head");

  a_idle_between_runs: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop_o |=> (tri_r == 3'd0 && sub_r == 2'd0 && lit_r == 3'd0))
    else $error("expander counters not cleared after a run");

  a_repl_triple_order: assert property (@(posedge clk) disable iff (!rst_n)
    (load && in_repl && sub_r == 2'd0) |=> (byte_r == REPL_B0 && repl_r))
    else $error("replacement triple out of order");

endmodule

`default_nettype wire

// ===== design/utf8_sanitize_replace.sv =====
// Top level of the streaming UTF-8 sanitiser.
// Depends on u8s_pkg, u8s_front, u8s_fifo and u8s_back.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input side is a queue write port: in_data_byte / in_end_of_text are taken
//   on a rising edge with push high and full low. Output side is a queue read
//   port: while empty is low the oldest result byte sits on out_byte,
//   out_is_replacement and out_last_of_run; pop high with empty low takes it.
//   Each input byte yields 0 to 12 result bytes; out_last_of_run marks the
//   last one of a byte's run. A byte that is only held inside a pending
//   sequence yields nothing until the sequence completes or fails.
//   The descriptor is queued at the accepting edge, and its first result
//   byte is loaded into the output register once the runs ahead of it are
//   out and that register is free; empty then falls. Throughput: one input
//   byte per cycle while each byte yields one result (plain ASCII) and the
//   receiver takes each one; the expander emits one result byte per cycle
//   while it is taken, so a byte with N results holds it until all N are
//   out, and a four-entry descriptor queue absorbs that before full rises.
//   Reset (rst_n low, synchronous) drops any pending sequence, empties the
//   queue and the output register. When the receiver stalls the result holds
//   and the queue fills; full then stalls the sender.

module utf8_sanitize_replace import u8s_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_text,
  // result channel
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_is_replacement,
  output logic            out_last_of_run
);

  logic      in_acc;     // input transaction this cycle
  logic      q_push, q_full, q_pop, q_avail;
  run_desc_t q_wdesc, q_head;
  logic      out_valid;

  assign in_acc = push && !full;
  assign full   = q_full;
  assign empty  = !out_valid;

  // Classifier keeps the sequence state and queues one descriptor per byte that yields output
  u8s_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_i    (in_acc),
    .data_i   (in_data_byte),
    .eot_i    (in_end_of_text),
    .q_push_o (q_push),
    .q_desc_o (q_wdesc)
  );

  u8s_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .desc_i  (q_wdesc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .head_o  (q_head)
  );

  // Expander turns descriptors into bytes behind the output register
  u8s_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .avail_i     (q_avail),
    .head_i      (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid),
    .out_byte_o  (out_byte),
    .out_repl_o  (out_is_replacement),
    .out_last_o  (out_last_of_run),
    .out_take_i  (pop && out_valid)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for utf8_sanitize_replace: queue-style push/pop on both sides.
// Depends on u8s_pkg for the replacement and restricted-lead byte constants.
`timescale 1ns / 1ps

module testbench;
  import u8s_pkg::*;

  localparam int RANDOM_ITEMS = 340;
  localparam int MAX_WAIT     = 8;
  localparam int DRAIN_CYCLES = 24;
  // Worst case is about 12 results per byte over ~370 bytes, each result held
  // up by the longest pop stall; the limit allows more than ten times that.
  localparam int CYCLE_LIMIT  = 600000;

  // One raw text byte as it goes into the block
  typedef struct packed {
    logic [7:0] value;
    logic       eot;
  } text_byte_t;

  // One sanitised byte as it leaves the block
  typedef struct packed {
    logic [7:0] value;
    logic       repl;
    logic       last;
  } out_beat_t;

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       push           = 1'b0;
  logic [7:0] in_data_byte   = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       pop            = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_is_replacement;
  logic       out_last_of_run;

  utf8_sanitize_replace dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_data_byte       (in_data_byte),
    .in_end_of_text     (in_end_of_text),
    .empty              (empty),
    .pop                (pop),
    .out_byte           (out_byte),
    .out_is_replacement (out_is_replacement),
    .out_last_of_run    (out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Book-keeping
  // ---------------------------------------------------------------------------
  text_byte_t text_to_send [$];   // filled up front, drained by the driver
  out_beat_t  bytes_due [$];      // predicted output bytes, oldest first

  int cycle_count    = 0;
  int errors         = 0;
  int bytes_taken    = 0;
  int eot_taken      = 0;
  int beats_checked  = 0;
  int repl_seen      = 0;
  int longest_run    = 0;
  int seqs_completed = 0;

  // Sanitiser state as the predictor sees it
  logic [7:0] seq_lead;
  int         seq_len;        // 0 = nothing pending, else 2..4
  int         seq_held;       // continuation bytes held so far
  logic [7:0] seq_cont [3];

  // Output run being assembled for the current transaction
  out_beat_t run_buf [12];
  int        run_len;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Expected sequence length for a fresh byte; 0 means not a valid lead
  function automatic int lead_length(input logic [7:0] b);
    if (b < 8'h80)                     return 1;
    else if (b >= 8'hC2 && b <= 8'hDF) return 2;
    else if (b >= 8'hE0 && b <= 8'hEF) return 3;
    else if (b >= 8'hF0 && b <= 8'hF4) return 4;
    return 0;
  endfunction

  // Overlong, surrogate and above-range forms are caught on the second byte
  function automatic logic second_byte_allowed(input logic [7:0] lead,
                                               input logic [7:0] b);
    if (lead == LEAD_E0 && b < 8'hA0) return 1'b0;
    if (lead == LEAD_ED && b > 8'h9F) return 1'b0;
    if (lead == LEAD_F0 && b < 8'h90) return 1'b0;
    if (lead == LEAD_F4 && b > 8'h8F) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void append_beat(input logic [7:0] b, input logic repl);
    run_buf[run_len] = {b, repl, 1'b0};
    run_len++;
  endfunction

  function automatic void append_fffd();
    append_beat(REPL_B0, 1'b1);
    append_beat(REPL_B1, 1'b1);
    append_beat(REPL_B2, 1'b1);
  endfunction

  // Lead plus every held byte becomes one U+FFFD each; sequence dropped
  function automatic void drop_sequence();
    int k;
    for (k = 0; k <= seq_held; k++) append_fffd();
    seq_len  = 0;
    seq_held = 0;
    seq_lead = 8'h00;
  endfunction

  function automatic void sanitise_byte(input logic [7:0] b, input logic eot);
    logic      taken;
    int        k;
    int        len;
    out_beat_t beat;
    run_len = 0;
    taken   = 1'b0;
    if (seq_len != 0) begin
      if (b[7:6] == 2'b10 && (seq_held != 0 || second_byte_allowed(seq_lead, b))) begin
        taken = 1'b1;
        if (seq_held + 2 >= seq_len) begin
          // sequence complete: release it unchanged
          append_beat(seq_lead, 1'b0);
          for (k = 0; k < seq_held; k++) append_beat(seq_cont[k], 1'b0);
          append_beat(b, 1'b0);
          seq_len  = 0;
          seq_held = 0;
          seq_lead = 8'h00;
          seqs_completed++;
        end else begin
          seq_cont[seq_held] = b;
          seq_held++;
        end
      end else begin
        drop_sequence();
      end
    end
    // a byte that broke a sequence is looked at again as a fresh byte
    if (!taken) begin
      len = lead_length(b);
      if (len == 1) append_beat(b, 1'b0);
      else if (len == 0) append_fffd();
      else begin
        seq_lead = b;
        seq_len  = len;
        seq_held = 0;
      end
    end
    if (eot && seq_len != 0) drop_sequence();
    for (k = 0; k < run_len; k++) begin
      beat      = run_buf[k];
      beat.last = (k == run_len - 1);
      bytes_due.insert(bytes_due.size(), beat);
    end
    if (run_len > longest_run) longest_run = run_len;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int draw_wait(input logic steady);
    return steady ? 0 : int'($urandom_range(MAX_WAIT, 0));
  endfunction

  function automatic logic draw_eot();
    return ($urandom_range(19, 0) == 0);
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic eot);
    text_byte_t t;
    t.value = b;
    t.eot   = eot;
    text_to_send.insert(text_to_send.size(), t);
  endtask

  // A well-formed sequence of len bytes with random content; only the first
  // keep bytes are queued, so keep < len gives a truncated one
  task automatic queue_sequence(input int len, input int keep);
    logic [7:0] seq [4];
    logic [7:0] lo;
    logic [7:0] hi;
    int         k;
    case (len)
      2:       seq[0] = 8'($urandom_range(8'hDF, 8'hC2));
      3:       seq[0] = 8'($urandom_range(8'hEF, 8'hE0));
      default: seq[0] = 8'($urandom_range(8'hF4, 8'hF0));
    endcase
    lo = 8'h80;
    hi = 8'hBF;
    if (seq[0] == LEAD_E0) lo = 8'hA0;
    if (seq[0] == LEAD_ED) hi = 8'h9F;
    if (seq[0] == LEAD_F0) lo = 8'h90;
    if (seq[0] == LEAD_F4) hi = 8'h8F;
    seq[1] = 8'($urandom_range(hi, lo));
    seq[2] = 8'($urandom_range(8'hBF, 8'h80));
    seq[3] = 8'($urandom_range(8'hBF, 8'h80));
    for (k = 0; k < keep; k++) queue_byte(seq[k], draw_eot());
  endtask

  // Restricted lead followed by a continuation just outside its range
  task automatic queue_bad_second();
    logic [7:0] lead;
    logic [7:0] second;
    case ($urandom_range(3, 0))
      0: begin lead = LEAD_E0; second = 8'($urandom_range(8'h9F, 8'h80)); end
      1: begin lead = LEAD_ED; second = 8'($urandom_range(8'hBF, 8'hA0)); end
      2: begin lead = LEAD_F0; second = 8'($urandom_range(8'h8F, 8'h80)); end
      default: begin lead = LEAD_F4; second = 8'($urandom_range(8'hBF, 8'h90)); end
    endcase
    queue_byte(lead, 1'b0);
    queue_byte(second, draw_eot());
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued bytes, predicts on each accepted transaction
  // ---------------------------------------------------------------------------
  int         in_wait   = 0;
  logic       in_steady = 1'b0;
  text_byte_t next_text;

  always @(posedge clk) begin
    if (!rst_n) begin
      push    <= 1'b0;
      in_wait = 0;
    end else begin
      if (push && !full) begin
        sanitise_byte(in_data_byte, in_end_of_text);
        bytes_taken++;
        if (in_end_of_text) eot_taken++;
        if ($urandom_range(11, 0) == 0) in_steady = !in_steady;
        in_wait = draw_wait(in_steady);
      end
      if (push && full) begin
        // stalled: hold the transaction as it is
      end else if (in_wait != 0) begin
        in_wait--;
        push <= 1'b0;
      end else if (text_to_send.size() != 0) begin
        next_text = text_to_send.pop_front();
        push           <= 1'b1;
        in_data_byte   <= next_text.value;
        in_end_of_text <= next_text.eot;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: pops results with random stalls and checks each against the
  // oldest prediction
  // ---------------------------------------------------------------------------
  int        out_wait   = 0;
  logic      out_steady = 1'b0;
  out_beat_t want;

  task automatic report_mismatch(input string what);
    $display("cycle %0d: mismatch, %s", cycle_count, what);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pop      <= 1'b0;
      out_wait = 0;
    end else begin
      if (pop && !empty) begin
        beats_checked++;
        if (out_is_replacement === 1'b1) repl_seen++;
        if (bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %h", out_byte));
        end else begin
          want = bytes_due.pop_front();
          if (out_byte !== want.value)
            report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.value));
          if (out_is_replacement !== want.repl)
            report_mismatch($sformatf("out_is_replacement %b, want %b on byte %h",
                                      out_is_replacement, want.repl, want.value));
          if (out_last_of_run !== want.last)
            report_mismatch($sformatf("out_last_of_run %b, want %b on byte %h",
                                      out_last_of_run, want.last, want.value));
        end
        if ($urandom_range(11, 0) == 0) out_steady = !out_steady;
        out_wait = draw_wait(out_steady);
      end
      if (out_wait != 0) begin
        out_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d bytes still due", bytes_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  int first_random;
  int pick;
  int len;

  initial begin
    seq_lead = 8'h00;
    seq_len  = 0;
    seq_held = 0;

    // Directed: ASCII extremes, shortest and longest valid forms, each
    // restricted-lead rejection, invalid leads, bad continuation after two
    // held bytes, and truncation by end of text
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hC2, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'hE0, 1'b0); queue_byte(8'hA0, 1'b0); queue_byte(8'hBF, 1'b0);
    queue_byte(8'hE0, 1'b0); queue_byte(8'h9F, 1'b0);    // overlong
    queue_byte(8'hED, 1'b0); queue_byte(8'hA0, 1'b0);    // surrogate
    queue_byte(8'hF0, 1'b0); queue_byte(8'h8F, 1'b0);    // overlong
    queue_byte(8'hF4, 1'b0); queue_byte(8'h8F, 1'b0);
    queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b0);
    queue_byte(8'hF4, 1'b0); queue_byte(8'h90, 1'b0);    // above U+10FFFF
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hF1, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'h80, 1'b0); queue_byte(8'h41, 1'b0);    // broken after two held
    queue_byte(8'hF0, 1'b0); queue_byte(8'h90, 1'b0);
    queue_byte(8'h80, 1'b0); queue_byte(8'hF0, 1'b1);    // worst-case burst

    // Random: mostly well-formed text, then truncations, range faults, noise
    first_random = text_to_send.size();
    while (text_to_send.size() - first_random < RANDOM_ITEMS) begin
      pick = $urandom_range(99, 0);
      if (pick < 30) queue_byte(8'($urandom_range(8'h7F, 8'h00)), draw_eot());
      else if (pick < 45) queue_sequence(2, 2);
      else if (pick < 60) queue_sequence(3, 3);
      else if (pick < 72) queue_sequence(4, 4);
      else if (pick < 84) begin
        len = $urandom_range(4, 2);
        queue_sequence(len, $urandom_range(len - 1, 1));
      end else if (pick < 90) queue_bad_second();
      else queue_byte(8'($urandom_range(8'hFF, 8'h00)), draw_eot());
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // every byte taken and every prediction checked
    do @(negedge clk);
    while (text_to_send.size() != 0 || push || bytes_due.size() != 0);
    // catch anything the block emits beyond the prediction
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d text bytes (%0d with end of text); %0d sequences completed.",
             bytes_taken, eot_taken, seqs_completed);
    $display("Checked %0d output bytes, %0d of them replacement; longest run %0d.",
             beats_checked, repl_seen, longest_run);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
